@@ src/ciur_pkg.sv @@
// ----------------------------------------------------------------------------
// ciur_pkg
// Shared types and constants for the chunked image upload receiver.
// ----------------------------------------------------------------------------
package ciur_pkg;

  // Field widths fixed by the interface
  localparam int unsigned CB_W  = 10;  // chunk size register
  localparam int unsigned ACC_W = 26;  // shared unit datapath (16 x 10 product)

  // Item kinds
  localparam logic [2:0] KIND_START      = 3'd0;
  localparam logic [2:0] KIND_ABORT      = 3'd1;
  localparam logic [2:0] KIND_DATA       = 3'd2;
  localparam logic [2:0] KIND_DISCONNECT = 3'd3;

  // Response codes
  localparam logic [1:0] RESP_NONE     = 2'd0;
  localparam logic [1:0] RESP_READY    = 2'd1;
  localparam logic [1:0] RESP_ERROR    = 2'd2;
  localparam logic [1:0] RESP_COMPLETE = 2'd3;

  // Error codes
  localparam logic [2:0] ERR_NONE        = 3'd0;
  localparam logic [2:0] ERR_BAD_SIZE    = 3'd1;
  localparam logic [2:0] ERR_BUSY        = 3'd2;
  localparam logic [2:0] ERR_NOT_STARTED = 3'd3;
  localparam logic [2:0] ERR_WRONG_INDEX = 3'd4;

  // Event codes
  localparam logic [1:0] EV_NONE     = 2'd0;
  localparam logic [1:0] EV_STARTED  = 2'd1;
  localparam logic [1:0] EV_ABORTED  = 2'd2;
  localparam logic [1:0] EV_COMPLETE = 2'd3;

  // Message length minimums and chunk size after reset
  localparam logic [CB_W-1:0] START_MIN_LEN = 10'd5;
  localparam logic [CB_W-1:0] DATA_MIN_LEN  = 10'd3;
  localparam logic [CB_W-1:0] CB_RESET      = 10'd240;

  // Shared unit operations
  localparam logic OP_MUL = 1'b0;
  localparam logic OP_DIV = 1'b1;

  // Request to the shared unit
  typedef struct packed {
    logic start;
    logic op;
  } unit_req_t;

endpackage

@@ src/ciur_muldiv.sv @@
// ----------------------------------------------------------------------------
// ciur_muldiv
// Iterative multiply / divide around one shared adder-subtractor.
// Multiply is shift-and-add over the CB_W bits of the multiplier; divide is
// restoring, one quotient bit per cycle over DIV_STEPS bits.
// ----------------------------------------------------------------------------
module ciur_muldiv #(
  parameter int unsigned DIV_STEPS = 17
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  ciur_pkg::unit_req_t            req_i,
  input  logic [ciur_pkg::ACC_W-1:0]     a_i,     // multiplicand or dividend
  input  logic [ciur_pkg::CB_W-1:0]      b_i,     // multiplier or divisor
  output logic                           done_o,
  output logic [ciur_pkg::ACC_W-1:0]     result_o
);

  localparam int unsigned AW        = ciur_pkg::ACC_W;
  localparam int unsigned STEPS_MAX = (DIV_STEPS > ciur_pkg::CB_W) ? DIV_STEPS
                                                                   : ciur_pkg::CB_W;
  localparam int unsigned CNT_W     = $clog2(STEPS_MAX + 1);
  localparam logic [AW-1:0] QUO_MASK = (AW'(1) << DIV_STEPS) - AW'(1);

  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic            op_q, op_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [AW-1:0]   x_q, x_d;   // accumulator / remainder
  logic [AW-1:0]   y_q, y_d;   // shifted multiplicand / divisor
  logic [AW-1:0]   z_q, z_d;   // multiplier / dividend-quotient shifter

  logic [AW-1:0]   add_x, add_y;
  logic            add_sub;
  logic [AW:0]     add_sum;

  // Shared adder: subtract for a divide step, add for a multiply step
  always_comb begin
    add_sub = (op_q == ciur_pkg::OP_DIV);
    if (add_sub) begin
      add_x = {x_q[AW-2:0], z_q[DIV_STEPS-1]};
      add_y = y_q;
    end else begin
      add_x = x_q;
      add_y = z_q[0] ? y_q : '0;
    end
    add_sum = {1'b0, add_x} + {1'b0, (add_sub ? ~add_y : add_y)} + (AW + 1)'(add_sub);
  end

  // Step sequencing
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    op_d   = op_q;
    cnt_d  = cnt_q;
    x_d    = x_q;
    y_d    = y_q;
    z_d    = z_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      op_d   = req_i.op;
      x_d    = '0;
      if (req_i.op == ciur_pkg::OP_DIV) begin
        cnt_d = CNT_W'(DIV_STEPS);
        y_d   = AW'(b_i);
        z_d   = a_i;
      end else begin
        cnt_d = CNT_W'(ciur_pkg::CB_W);
        y_d   = a_i;
        z_d   = AW'(b_i);
      end
    end else if (busy_q) begin
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
      if (op_q == ciur_pkg::OP_DIV) begin
        // carry out set means the trial subtract did not borrow
        x_d = add_sum[AW] ? add_sum[AW-1:0] : add_x;
        z_d = {z_q[AW-2:0], add_sum[AW]};
      end else begin
        x_d = add_sum[AW-1:0];
        y_d = {y_q[AW-2:0], 1'b0};
        z_d = {1'b0, z_q[AW-1:1]};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q <= op_d;
    x_q  <= x_d;
    y_q  <= y_d;
    z_q  <= z_d;
  end

  assign done_o   = done_q;
  assign result_o = (op_q == ciur_pkg::OP_DIV) ? (z_q & QUO_MASK) : x_q;

  // Checks
  a_busy_cnt : assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> cnt_q != '0)
    else $error("muldiv busy with zero step count");
  a_done_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q)
    else $error("muldiv done while still busy");
  a_no_restart : assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> !busy_q)
    else $error("muldiv started while busy");

endmodule

@@ src/chunked_image_upload_receiver.sv @@
// ----------------------------------------------------------------------------
// chunked_image_upload_receiver
// Control block for a chunked image upload: start, abort, data chunk header,
// disconnect; one result item per input item.
// ----------------------------------------------------------------------------
// One item is worked on at a time; in_ready_o is high only between items. A
// start that opens an upload waits on the bit-serial divide in the shared
// multiply/divide unit. A data chunk in sequence takes 10 multiply steps for
// the byte offset, then the clamp and count steps. Every other item goes from
// decode straight to the emit step.
// The result sits in an output register, so a new item can be taken while
// the previous result waits; a finished item waits in its last step only if
// that register is still full.
module chunked_image_upload_receiver #(
  parameter int unsigned MAX_IMAGE_BYTES = 65536
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        cfg_we_i,
  input  logic [9:0]  cfg_wdata_i,
  // input items
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  kind_i,
  input  logic [9:0]  msg_length_i,
  input  logic [31:0] image_size_i,
  input  logic [15:0] chunk_index_i,
  input  logic        transfer_busy_i,
  input  logic        notify_enabled_i,
  // result items
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  response_o,
  output logic [2:0]  error_code_o,
  output logic [9:0]  ready_chunk_bytes_o,
  output logic [15:0] chunk_total_o,
  output logic        write_enable_o,
  output logic [15:0] write_offset_o,
  output logic [9:0]  write_length_o,
  output logic        image_done_o,
  output logic [1:0]  event_res_o,
  output logic        receiving_o,
  output logic [16:0] bytes_received_o,
  output logic [15:0] chunks_accepted_o
);

  localparam int unsigned AW        = ciur_pkg::ACC_W;
  localparam int unsigned TW        = $clog2(MAX_IMAGE_BYTES + 1);
  localparam int unsigned DIV_STEPS = $clog2(MAX_IMAGE_BYTES + 1024);

  // Sequencer states
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECODE = 3'd1;
  localparam logic [2:0] S_DIV    = 3'd2;
  localparam logic [2:0] S_MUL    = 3'd3;
  localparam logic [2:0] S_CLAMP  = 3'd4;
  localparam logic [2:0] S_COUNT  = 3'd5;
  localparam logic [2:0] S_EMIT   = 3'd6;

  logic [2:0]  state_q, state_d;
  logic [9:0]  chunk_bytes_q;
  logic [9:0]  cb;

  // latched item
  logic [2:0]  kind_q;
  logic [9:0]  mlen_q;
  logic [31:0] size_q;
  logic [15:0] cidx_q;
  logic        xfer_busy_q;
  logic        notify_q;

  // upload state
  logic          in_upload_q, in_upload_d;
  logic [TW-1:0] image_total_q, image_total_d;
  logic [TW-1:0] byte_count_q, byte_count_d;
  logic [15:0]   next_index_q, next_index_d;
  logic [15:0]   num_chunks_q, num_chunks_d;

  // scratch and staged result
  logic [AW-1:0] off_q, off_d;
  logic [9:0]    len_q, len_d;
  logic [1:0]    resp_q, resp_d;
  logic [2:0]    err_q, err_d;
  logic [9:0]    rdy_q, rdy_d;
  logic          wen_q, wen_d;
  logic [15:0]   woff_q, woff_d;
  logic          done_q, done_d;
  logic [1:0]    ev_q, ev_d;

  // output register
  logic        out_valid_q;
  logic [1:0]  o_resp_q;
  logic [2:0]  o_err_q;
  logic [9:0]  o_rdy_q;
  logic [15:0] o_ctot_q;
  logic        o_wen_q;
  logic [15:0] o_woff_q;
  logic [9:0]  o_wlen_q;
  logic        o_done_q;
  logic [1:0]  o_ev_q;
  logic        o_recv_q;
  logic [16:0] o_bytes_q;
  logic [15:0] o_chunks_q;

  logic                unit_done;
  logic [AW-1:0]       unit_res;
  logic [AW-1:0]       unit_a;
  ciur_pkg::unit_req_t unit_req;

  logic          accept;
  logic          slot_free;
  logic          emit;
  logic [AW-1:0] total_ext;
  logic [AW-1:0] remain;
  logic [AW-1:0] bc_sum;
  logic [9:0]    len_raw;
  logic [9:0]    len_clamp;
  logic [TW-1:0] bc_sat;
  logic [AW-1:0] bc_ext;

  assign cb        = (chunk_bytes_q == '0) ? 10'd1 : chunk_bytes_q;
  assign in_ready_o = (state_q == S_IDLE);
  assign accept    = in_valid_i && in_ready_o;
  assign slot_free = !out_valid_q || out_ready_i;
  assign emit      = (state_q == S_EMIT) && slot_free;

  // Data chunk clamp arithmetic
  assign total_ext = AW'(image_total_q);
  assign remain    = total_ext - off_q;
  assign len_raw   = mlen_q - 10'd2;
  always_comb begin
    if (off_q >= total_ext) begin
      len_clamp = '0;
    end else if (AW'(len_raw) > remain) begin
      len_clamp = remain[9:0];
    end else begin
      len_clamp = len_raw;
    end
  end

  // Byte count update, saturating at the image size
  assign bc_sum = AW'(byte_count_q) + AW'(len_q);
  assign bc_sat = (bc_sum > total_ext) ? image_total_q : bc_sum[TW-1:0];

  // Sequencer
  always_comb begin
    state_d       = state_q;
    in_upload_d   = in_upload_q;
    image_total_d = image_total_q;
    byte_count_d  = byte_count_q;
    next_index_d  = next_index_q;
    num_chunks_d  = num_chunks_q;
    off_d         = off_q;
    len_d         = len_q;
    resp_d        = resp_q;
    err_d         = err_q;
    rdy_d         = rdy_q;
    wen_d         = wen_q;
    woff_d        = woff_q;
    done_d        = done_q;
    ev_d          = ev_q;
    unit_req      = '{start: 1'b0, op: ciur_pkg::OP_MUL};
    unit_a        = AW'(cidx_q);

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_DECODE;
          resp_d  = ciur_pkg::RESP_NONE;
          err_d   = ciur_pkg::ERR_NONE;
          rdy_d   = '0;
          wen_d   = 1'b0;
          woff_d  = '0;
          len_d   = '0;
          done_d  = 1'b0;
          ev_d    = ciur_pkg::EV_NONE;
        end
      end

      S_DECODE: begin
        state_d = S_EMIT;
        if (kind_q == ciur_pkg::KIND_START && mlen_q != '0) begin
          if (mlen_q < ciur_pkg::START_MIN_LEN) begin
            resp_d = ciur_pkg::RESP_ERROR;
            err_d  = ciur_pkg::ERR_BAD_SIZE;
          end else if (xfer_busy_q) begin
            resp_d = ciur_pkg::RESP_ERROR;
            err_d  = ciur_pkg::ERR_BUSY;
          end else if (size_q == '0 || size_q > 32'(MAX_IMAGE_BYTES)) begin
            resp_d = ciur_pkg::RESP_ERROR;
            err_d  = ciur_pkg::ERR_BAD_SIZE;
          end else begin
            // ceiling divide: (size + cb - 1) / cb
            unit_req = '{start: 1'b1, op: ciur_pkg::OP_DIV};
            unit_a   = AW'(size_q[TW-1:0]) + AW'(cb) - AW'(1);
            state_d  = S_DIV;
          end
        end else if (kind_q == ciur_pkg::KIND_ABORT && mlen_q != '0) begin
          if (in_upload_q) begin
            in_upload_d   = 1'b0;
            image_total_d = '0;
            byte_count_d  = '0;
            next_index_d  = '0;
            num_chunks_d  = '0;
            ev_d          = ciur_pkg::EV_ABORTED;
          end
        end else if (kind_q == ciur_pkg::KIND_DATA) begin
          if (!in_upload_q) begin
            resp_d = ciur_pkg::RESP_ERROR;
            err_d  = ciur_pkg::ERR_NOT_STARTED;
          end else if (mlen_q >= ciur_pkg::DATA_MIN_LEN) begin
            if (cidx_q != next_index_q) begin
              resp_d        = ciur_pkg::RESP_ERROR;
              err_d         = ciur_pkg::ERR_WRONG_INDEX;
              in_upload_d   = 1'b0;
              image_total_d = '0;
              byte_count_d  = '0;
              next_index_d  = '0;
              num_chunks_d  = '0;
            end else begin
              // byte offset = index * cb
              unit_req = '{start: 1'b1, op: ciur_pkg::OP_MUL};
              unit_a   = AW'(cidx_q);
              state_d  = S_MUL;
            end
          end
        end else if (kind_q == ciur_pkg::KIND_DISCONNECT) begin
          if (in_upload_q) begin
            in_upload_d   = 1'b0;
            image_total_d = '0;
            byte_count_d  = '0;
            next_index_d  = '0;
            num_chunks_d  = '0;
          end
        end
      end

      S_DIV: begin
        if (unit_done) begin
          in_upload_d   = 1'b1;
          image_total_d = size_q[TW-1:0];
          byte_count_d  = '0;
          next_index_d  = '0;
          num_chunks_d  = (|unit_res[AW-1:16]) ? 16'hFFFF : unit_res[15:0];
          resp_d        = ciur_pkg::RESP_READY;
          rdy_d         = cb;
          ev_d          = ciur_pkg::EV_STARTED;
          state_d       = S_EMIT;
        end
      end

      S_MUL: begin
        if (unit_done) begin
          off_d   = unit_res;
          state_d = S_CLAMP;
        end
      end

      S_CLAMP: begin
        len_d        = len_clamp;
        wen_d        = (len_clamp != '0);
        woff_d       = (len_clamp != '0) ? off_q[15:0] : 16'd0;
        next_index_d = next_index_q + 16'd1;
        state_d      = S_COUNT;
      end

      S_COUNT: begin
        byte_count_d = bc_sat;
        if (bc_sat >= image_total_q) begin
          resp_d      = ciur_pkg::RESP_COMPLETE;
          done_d      = 1'b1;
          ev_d        = ciur_pkg::EV_COMPLETE;
          in_upload_d = 1'b0;
        end
        state_d = S_EMIT;
      end

      S_EMIT: begin
        if (slot_free) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      chunk_bytes_q <= ciur_pkg::CB_RESET;
      in_upload_q   <= 1'b0;
      image_total_q <= '0;
      byte_count_q  <= '0;
      next_index_q  <= '0;
      num_chunks_q  <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      in_upload_q   <= in_upload_d;
      image_total_q <= image_total_d;
      byte_count_q  <= byte_count_d;
      next_index_q  <= next_index_d;
      num_chunks_q  <= num_chunks_d;
      if (cfg_we_i) begin
        chunk_bytes_q <= cfg_wdata_i;
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Item capture, scratch and staged result
  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q      <= kind_i;
      mlen_q      <= msg_length_i;
      size_q      <= image_size_i;
      cidx_q      <= chunk_index_i;
      xfer_busy_q <= transfer_busy_i;
      notify_q    <= notify_enabled_i;
    end
    off_q  <= off_d;
    len_q  <= len_d;
    resp_q <= resp_d;
    err_q  <= err_d;
    rdy_q  <= rdy_d;
    wen_q  <= wen_d;
    woff_q <= woff_d;
    done_q <= done_d;
    ev_q   <= ev_d;
  end

  // Output register; responses are masked when notifications are off
  assign bc_ext = AW'(byte_count_q);
  always_ff @(posedge clk_i) begin
    if (emit) begin
      o_resp_q   <= notify_q ? resp_q : ciur_pkg::RESP_NONE;
      o_err_q    <= notify_q ? err_q : ciur_pkg::ERR_NONE;
      o_rdy_q    <= notify_q ? rdy_q : 10'd0;
      o_ctot_q   <= num_chunks_q;
      o_wen_q    <= wen_q;
      o_woff_q   <= woff_q;
      o_wlen_q   <= len_q;
      o_done_q   <= done_q;
      o_ev_q     <= ev_q;
      o_recv_q   <= in_upload_q;
      o_bytes_q  <= bc_ext[16:0];
      o_chunks_q <= next_index_q;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign response_o          = o_resp_q;
  assign error_code_o        = o_err_q;
  assign ready_chunk_bytes_o = o_rdy_q;
  assign chunk_total_o       = o_ctot_q;
  assign write_enable_o      = o_wen_q;
  assign write_offset_o      = o_woff_q;
  assign write_length_o      = o_wlen_q;
  assign image_done_o        = o_done_q;
  assign event_res_o         = o_ev_q;
  assign receiving_o         = o_recv_q;
  assign bytes_received_o    = o_bytes_q;
  assign chunks_accepted_o   = o_chunks_q;

  // Shared multiply / divide unit
  ciur_muldiv #(
    .DIV_STEPS (DIV_STEPS)
  ) u_muldiv (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (unit_req),
    .a_i      (unit_a),
    .b_i      (cb),
    .done_o   (unit_done),
    .result_o (unit_res)
  );

  // Checks
  a_done_in_wait : assert property (@(posedge clk_i) disable iff (!rst_ni)
    unit_done |-> (state_q == S_DIV || state_q == S_MUL))
    else $error("unit finished outside a wait state");
  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    byte_count_q <= image_total_q)
    else $error("byte count above image size");
  a_open_size : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_upload_q |-> image_total_q != '0)
    else $error("upload open with zero size");
  a_emit_loads : assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |=> out_valid_q && state_q == S_IDLE)
    else $error("result not loaded on emit");

endmodule

@@ tb/upload_response_checker.sv @@
// ----------------------------------------------------------------------------
// upload_response_checker
// Watches the item and result channels of the upload receiver, keeps its own
// copy of the upload state and chunk size, predicts each result item and
// compares it field by field with what the block returns.
// ----------------------------------------------------------------------------
module upload_response_checker #(
  parameter int unsigned MAX_IMAGE_BYTES = 65536
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        cfg_we_i,
  input  logic [9:0]  cfg_wdata_i,
  // input items
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [2:0]  kind_i,
  input  logic [9:0]  msg_length_i,
  input  logic [31:0] image_size_i,
  input  logic [15:0] chunk_index_i,
  input  logic        transfer_busy_i,
  input  logic        notify_enabled_i,
  // result items
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [1:0]  response_i,
  input  logic [2:0]  error_code_i,
  input  logic [9:0]  ready_chunk_bytes_i,
  input  logic [15:0] chunk_total_i,
  input  logic        write_enable_i,
  input  logic [15:0] write_offset_i,
  input  logic [9:0]  write_length_i,
  input  logic        image_done_i,
  input  logic [1:0]  event_res_i,
  input  logic        receiving_i,
  input  logic [16:0] bytes_received_i,
  input  logic [15:0] chunks_accepted_i,
  // status to the test top
  output int unsigned mismatch_count_o,
  output int unsigned pending_count_o
);

  typedef struct packed {
    logic [1:0]  response;
    logic [2:0]  error_code;
    logic [9:0]  ready_chunk_bytes;
    logic [15:0] chunk_total;
    logic        write_enable;
    logic [15:0] write_offset;
    logic [9:0]  write_length;
    logic        image_done;
    logic [1:0]  event_res;
    logic        receiving;
    logic [16:0] bytes_received;
    logic [15:0] chunks_accepted;
  } upload_result_t;

  // Shadow of the block's register and upload state
  logic [9:0]  chunk_bytes;
  logic        in_upload;
  logic [16:0] image_total;
  logic [16:0] byte_count;
  logic [15:0] next_index;
  logic [15:0] num_chunks;

  upload_result_t expected_results[$];
  upload_result_t oldest;
  int unsigned    mismatches;

  function automatic void clear_upload_state();
    in_upload   = 1'b0;
    image_total = '0;
    byte_count  = '0;
    next_index  = '0;
    num_chunks  = '0;
  endfunction

  // Expected result of one item; advances the shadow state
  function automatic upload_result_t predict_upload_step(
    input logic [2:0]  kind,
    input logic [9:0]  mlen,
    input logic [31:0] size,
    input logic [15:0] idx,
    input logic        busy,
    input logic        notify
  );
    upload_result_t r;
    int unsigned    cb;
    int unsigned    n;
    int unsigned    off;
    int unsigned    len;
    int unsigned    sum;
    r  = '0;
    cb = (chunk_bytes == '0) ? 32'd1 : 32'(chunk_bytes);
    case (kind)
      ciur_pkg::KIND_START: begin
        if (mlen != '0) begin
          if (mlen < ciur_pkg::START_MIN_LEN) begin
            r.response   = ciur_pkg::RESP_ERROR;
            r.error_code = ciur_pkg::ERR_BAD_SIZE;
          end else if (busy) begin
            r.response   = ciur_pkg::RESP_ERROR;
            r.error_code = ciur_pkg::ERR_BUSY;
          end else if (size == 0 || size > MAX_IMAGE_BYTES) begin
            r.response   = ciur_pkg::RESP_ERROR;
            r.error_code = ciur_pkg::ERR_BAD_SIZE;
          end else begin
            clear_upload_state();
            image_total = size[16:0];
            n = (size + cb - 1) / cb;
            num_chunks = (n > 32'hFFFF) ? 16'hFFFF : n[15:0];
            in_upload = 1'b1;
            r.response          = ciur_pkg::RESP_READY;
            r.ready_chunk_bytes = cb[9:0];
            r.event_res         = ciur_pkg::EV_STARTED;
          end
        end
      end
      ciur_pkg::KIND_ABORT: begin
        if (mlen != '0 && in_upload) begin
          clear_upload_state();
          r.event_res = ciur_pkg::EV_ABORTED;
        end
      end
      ciur_pkg::KIND_DATA: begin
        if (!in_upload) begin
          r.response   = ciur_pkg::RESP_ERROR;
          r.error_code = ciur_pkg::ERR_NOT_STARTED;
        end else if (mlen >= ciur_pkg::DATA_MIN_LEN) begin
          if (idx != next_index) begin
            r.response   = ciur_pkg::RESP_ERROR;
            r.error_code = ciur_pkg::ERR_WRONG_INDEX;
            clear_upload_state();
          end else begin
            off = 32'(idx) * cb;
            len = 32'(mlen) - 32'd2;
            // truncate at the image end, nothing past it
            if (off >= 32'(image_total)) len = 0;
            else if (len > 32'(image_total) - off) len = 32'(image_total) - off;
            if (len != 0) begin
              r.write_enable = 1'b1;
              r.write_offset = off[15:0];
              r.write_length = len[9:0];
            end
            sum = 32'(byte_count) + len;
            if (sum > 32'(image_total)) sum = 32'(image_total);
            byte_count = sum[16:0];
            next_index = next_index + 16'd1;
            if (byte_count >= image_total) begin
              r.response   = ciur_pkg::RESP_COMPLETE;
              r.image_done = 1'b1;
              r.event_res  = ciur_pkg::EV_COMPLETE;
              in_upload    = 1'b0;
            end
          end
        end
      end
      ciur_pkg::KIND_DISCONNECT: begin
        if (in_upload) clear_upload_state();
      end
      default: ;
    endcase
    if (!notify) begin
      r.response          = ciur_pkg::RESP_NONE;
      r.error_code        = ciur_pkg::ERR_NONE;
      r.ready_chunk_bytes = '0;
    end
    r.chunk_total     = num_chunks;
    r.receiving       = in_upload;
    r.bytes_received  = byte_count;
    r.chunks_accepted = next_index;
    return r;
  endfunction

  task automatic compare_field(input string name, input logic [31:0] expv,
                               input logic [31:0] actv);
    if (actv !== expv) begin
      $error("%s: expected %0d, got %0d", name, expv, actv);
      mismatches++;
    end
  endtask

  // Results are taken before new items so a same-edge pair stays in order
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chunk_bytes = ciur_pkg::CB_RESET;
      clear_upload_state();
      expected_results.delete();
      mismatches = 0;
      mismatch_count_o <= 0;
      pending_count_o  <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (expected_results.size() == 0) begin
          $error("result item with no item pending");
          mismatches++;
        end else begin
          oldest = expected_results.pop_front();
          compare_field("response", 32'(oldest.response), 32'(response_i));
          compare_field("error_code", 32'(oldest.error_code), 32'(error_code_i));
          compare_field("ready_chunk_bytes", 32'(oldest.ready_chunk_bytes),
                        32'(ready_chunk_bytes_i));
          compare_field("chunk_total", 32'(oldest.chunk_total), 32'(chunk_total_i));
          compare_field("write_enable", 32'(oldest.write_enable),
                        32'(write_enable_i));
          compare_field("write_offset", 32'(oldest.write_offset),
                        32'(write_offset_i));
          compare_field("write_length", 32'(oldest.write_length),
                        32'(write_length_i));
          compare_field("image_done", 32'(oldest.image_done), 32'(image_done_i));
          compare_field("event_res", 32'(oldest.event_res), 32'(event_res_i));
          compare_field("receiving", 32'(oldest.receiving), 32'(receiving_i));
          compare_field("bytes_received", 32'(oldest.bytes_received),
                        32'(bytes_received_i));
          compare_field("chunks_accepted", 32'(oldest.chunks_accepted),
                        32'(chunks_accepted_i));
        end
      end
      if (in_valid_i && in_ready_i) begin
        expected_results.push_back(predict_upload_step(kind_i, msg_length_i,
          image_size_i, chunk_index_i, transfer_busy_i, notify_enabled_i));
      end
      if (cfg_we_i) chunk_bytes = cfg_wdata_i;
      mismatch_count_o <= mismatches;
      pending_count_o  <= expected_results.size();
    end
  end

endmodule

@@ tb/chunked_image_upload_receiver_test.sv @@
// ----------------------------------------------------------------------------
// chunked_image_upload_receiver_test
// Drives start, abort, data chunk, disconnect and stray command items into the
// upload receiver: a directed pass over the corner cases, then random uploads
// under several chunk sizes, with bursty input and a stalling result side.
// The checker beside the block predicts and compares every result item.
// ----------------------------------------------------------------------------
module chunked_image_upload_receiver_test;

  localparam int unsigned MAX_BYTES    = 65536;
  localparam int unsigned STALL_LIMIT  = 3000;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned PHASE_ITEMS  = 225;
  localparam logic [2:0]  KIND_UNKNOWN = 3'd4;
  localparam logic [2:0]  KIND_UNUSED  = 3'd7;

  logic        clk_i            = 1'b0;
  logic        rst_ni           = 1'b0;
  logic        cfg_we_i         = 1'b0;
  logic [9:0]  cfg_wdata_i      = '0;
  logic        in_valid_i       = 1'b0;
  logic        in_ready_o;
  logic [2:0]  kind_i           = '0;
  logic [9:0]  msg_length_i     = '0;
  logic [31:0] image_size_i     = '0;
  logic [15:0] chunk_index_i    = '0;
  logic        transfer_busy_i  = 1'b0;
  logic        notify_enabled_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i      = 1'b0;
  logic [1:0]  response_o;
  logic [2:0]  error_code_o;
  logic [9:0]  ready_chunk_bytes_o;
  logic [15:0] chunk_total_o;
  logic        write_enable_o;
  logic [15:0] write_offset_o;
  logic [9:0]  write_length_o;
  logic        image_done_o;
  logic [1:0]  event_res_o;
  logic        receiving_o;
  logic [16:0] bytes_received_o;
  logic [15:0] chunks_accepted_o;

  int unsigned mismatch_count;
  int unsigned pending_count;
  int unsigned stall_cycles = 0;
  int          burst_left   = 0;
  logic [9:0]  cur_cb       = ciur_pkg::CB_RESET;
  logic        hold_request = 1'b0;

  always #5 clk_i = ~clk_i;

  chunked_image_upload_receiver #(
    .MAX_IMAGE_BYTES(MAX_BYTES)
  ) dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .in_valid_i, .in_ready_o, .kind_i, .msg_length_i, .image_size_i,
    .chunk_index_i, .transfer_busy_i, .notify_enabled_i,
    .out_valid_o, .out_ready_i, .response_o, .error_code_o,
    .ready_chunk_bytes_o, .chunk_total_o, .write_enable_o, .write_offset_o,
    .write_length_o, .image_done_o, .event_res_o, .receiving_o,
    .bytes_received_o, .chunks_accepted_o
  );

  upload_response_checker #(
    .MAX_IMAGE_BYTES(MAX_BYTES)
  ) checker_i (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .in_valid_i, .in_ready_i(in_ready_o), .kind_i, .msg_length_i,
    .image_size_i, .chunk_index_i, .transfer_busy_i, .notify_enabled_i,
    .out_valid_i(out_valid_o), .out_ready_i,
    .response_i(response_o), .error_code_i(error_code_o),
    .ready_chunk_bytes_i(ready_chunk_bytes_o), .chunk_total_i(chunk_total_o),
    .write_enable_i(write_enable_o), .write_offset_i(write_offset_o),
    .write_length_i(write_length_o), .image_done_i(image_done_o),
    .event_res_i(event_res_o), .receiving_i(receiving_o),
    .bytes_received_i(bytes_received_o), .chunks_accepted_i(chunks_accepted_o),
    .mismatch_count_o(mismatch_count), .pending_count_o(pending_count)
  );

  // Offer one item and hold it until accepted; gaps fall between bursts
  task automatic send_item(input logic [2:0] kind, input logic [9:0] mlen,
                           input logic [31:0] size, input logic [15:0] idx,
                           input logic busy, input logic notify);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i       <= 1'b1;
    kind_i           <= kind;
    msg_length_i     <= mlen;
    image_size_i     <= size;
    chunk_index_i    <= idx;
    transfer_busy_i  <= busy;
    notify_enabled_i <= notify;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Chunk size changes only once every result has come back
  task automatic write_chunk_bytes(input logic [9:0] value);
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_count != 0) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    cur_cb = value;
    burst_left = 0;
  endtask

  // Mostly well-formed uploads with random content, the rest stray items
  task automatic random_uploads(input int n_items);
    int          sent;
    int          r;
    int          chunks;
    int          eff_cb;
    int          i;
    logic [15:0] idx;
    logic [31:0] size;
    logic [9:0]  mlen;
    eff_cb = (cur_cb == '0) ? 1 : int'(cur_cb);
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 99) < 80) begin
        case ($urandom_range(0, 9))
          0:       size = $urandom_range(1, MAX_BYTES);
          1:       size = $urandom_range(0, 1) ? MAX_BYTES : 1;
          default: size = $urandom_range(1, 8 * eff_cb);
        endcase
        if (size > MAX_BYTES) size = MAX_BYTES;
        send_item(ciur_pkg::KIND_START, 10'($urandom_range(5, 1023)), size,
                  16'($urandom), $urandom_range(0, 9) == 0,
                  $urandom_range(0, 7) != 0);
        sent++;
        chunks = (size + eff_cb - 1) / eff_cb;
        if (chunks > 12) chunks = 12;
        idx = '0;
        i = 0;
        while (i <= chunks && sent < n_items) begin
          r = $urandom_range(0, 99);
          if (r < 4) begin
            send_item(ciur_pkg::KIND_DATA, 10'($urandom_range(3, 1023)), $urandom,
                      idx + 16'($urandom_range(1, 65535)), 1'($urandom_range(0, 1)),
                      $urandom_range(0, 7) != 0);
          end else if (r < 7) begin
            send_item(ciur_pkg::KIND_ABORT, 10'($urandom_range(1, 1023)), $urandom,
                      16'($urandom), 1'($urandom_range(0, 1)),
                      $urandom_range(0, 7) != 0);
          end else if (r < 9) begin
            send_item(ciur_pkg::KIND_DISCONNECT, 10'($urandom), $urandom,
                      16'($urandom), 1'($urandom_range(0, 1)),
                      $urandom_range(0, 7) != 0);
          end else if (r < 14) begin
            send_item(ciur_pkg::KIND_DATA, 10'($urandom_range(0, 2)), $urandom, idx,
                      1'($urandom_range(0, 1)), $urandom_range(0, 7) != 0);
          end else begin
            if ($urandom_range(0, 3) != 0)
              mlen = (eff_cb + 2 > 1023) ? 10'd1023 : 10'(eff_cb + 2);
            else
              mlen = 10'($urandom_range(3, 1023));
            send_item(ciur_pkg::KIND_DATA, mlen, $urandom, idx,
                      1'($urandom_range(0, 1)), $urandom_range(0, 7) != 0);
            idx++;
          end
          sent++;
          i++;
        end
      end else begin
        send_item(3'($urandom_range(0, 7)), 10'($urandom), $urandom, 16'($urandom),
                  1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        sent++;
      end
    end
  endtask

  // Result side: ready always, coin flip, or mostly stalled, plus one long hold
  initial begin
    int mode;
    int span;
    @(posedge rst_ni);
    forever begin
      mode = $urandom_range(0, 2);
      span = $urandom_range(10, 80);
      repeat (span) begin
        @(posedge clk_i);
        if (hold_request) begin
          out_ready_i <= 1'b0;
          repeat (HOLD_CYCLES) @(posedge clk_i);
          hold_request = 1'b0;
        end
        case (mode)
          0:       out_ready_i <= 1'b1;
          1:       out_ready_i <= 1'($urandom_range(0, 1));
          default: out_ready_i <= ($urandom_range(0, 7) == 0);
        endcase
      end
    end
  end

  // Watchdog on cycles with no item moving on either channel
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles == STALL_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // Stimulus and verdict
  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty and stray commands, idle-state items
    send_item(ciur_pkg::KIND_START, 10'd0, 32'd500, 16'd0, 1'b0, 1'b1);
    send_item(ciur_pkg::KIND_ABORT, 10'd0, 32'd0, 16'd0, 1'b0, 1'b1);
    send_item(KIND_UNKNOWN, 10'd7, 32'd0, 16'd0, 1'b0, 1'b1);
    send_item(ciur_pkg::KIND_DATA, 10'd10, 32'd0, 16'd0, 1'b0, 1'b1);
    send_item(ciur_pkg::KIND_ABORT, 10'd5, 32'd0, 16'd0, 1'b0, 1'b1);
    send_item(ciur_pkg::KIND_DISCONNECT, 10'd0, 32'd0, 16'd0, 1'b0, 1'b1);
    // rejected starts: short, busy, zero size, too large
    send_item(ciur_pkg::KIND_START, 10'd4, 32'd500, 16'd0, 1'b0, 1'b1);
    send_item(ciur_pkg::KIND_START, 10'd9, 32'd500, 16'd0, 1'b1, 1'b1);
    send_item(ciur_pkg::KIND_START, 10'd9, 32'd0, 16'd0, 1'b0, 1'b1);
    send_item(ciur_pkg::KIND_START, 10'd9, MAX_BYTES + 1, 16'd0, 1'b0, 1'b1);
    send_item(ciur_pkg::KIND_START, 10'd1023, 32'hFFFF_FFFF, 16'hFFFF, 1'b0, 1'b1);
    // open with notifications off, short chunk, one chunk, wrong index
    send_item(ciur_pkg::KIND_START, 10'd9, 32'd500, 16'd0, 1'b0, 1'b0);
    send_item(ciur_pkg::KIND_DATA, 10'd2, 32'd0, 16'd0, 1'b0, 1'b1);
    send_item(ciur_pkg::KIND_DATA, 10'd242, 32'd0, 16'd0, 1'b0, 1'b1);
    send_item(ciur_pkg::KIND_DATA, 10'd100, 32'd0, 16'hFFFF, 1'b0, 1'b1);
    // one-byte image completes on a truncated chunk
    send_item(ciur_pkg::KIND_START, 10'd5, 32'd1, 16'd0, 1'b0, 1'b1);
    send_item(ciur_pkg::KIND_DATA, 10'd1023, 32'd0, 16'd0, 1'b1, 1'b1);
    // largest image, restart during upload, abort, disconnect
    send_item(ciur_pkg::KIND_START, 10'd1023, MAX_BYTES, 16'd0, 1'b0, 1'b1);
    send_item(ciur_pkg::KIND_START, 10'd6, 32'd300, 16'd0, 1'b0, 1'b1);
    send_item(ciur_pkg::KIND_DATA, 10'd3, 32'd0, 16'd0, 1'b0, 1'b1);
    send_item(ciur_pkg::KIND_ABORT, 10'd1, 32'd0, 16'd0, 1'b0, 1'b1);
    send_item(ciur_pkg::KIND_START, 10'd5, 32'd100, 16'd0, 1'b0, 1'b1);
    send_item(ciur_pkg::KIND_DISCONNECT, 10'd1023, 32'd0, 16'd0, 1'b0, 1'b1);
    send_item(KIND_UNUSED, 10'd1023, 32'hFFFF_FFFF, 16'hFFFF, 1'b1, 1'b1);

    // widest chunk: a chunk starting past the image end stores nothing
    write_chunk_bytes(10'd1023);
    send_item(ciur_pkg::KIND_START, 10'd5, 32'd2000, 16'd0, 1'b0, 1'b1);
    send_item(ciur_pkg::KIND_DATA, 10'd3, 32'd0, 16'd0, 1'b0, 1'b1);
    send_item(ciur_pkg::KIND_DATA, 10'd1023, 32'd0, 16'd1, 1'b0, 1'b1);
    send_item(ciur_pkg::KIND_DATA, 10'd1023, 32'd0, 16'd2, 1'b0, 1'b1);

    // zero chunk size acts as one; chunk count saturates
    write_chunk_bytes(10'd0);
    send_item(ciur_pkg::KIND_START, 10'd5, MAX_BYTES, 16'd0, 1'b0, 1'b1);
    send_item(ciur_pkg::KIND_DATA, 10'd1023, 32'd0, 16'd0, 1'b0, 1'b1);
    send_item(ciur_pkg::KIND_START, 10'd5, 32'd10, 16'd0, 1'b0, 1'b1);

    // random phases under several chunk sizes; one long result hold-off
    write_chunk_bytes(10'd1);
    random_uploads(PHASE_ITEMS);
    write_chunk_bytes(10'd1023);
    hold_request = 1'b1;
    random_uploads(PHASE_ITEMS);
    write_chunk_bytes(10'($urandom_range(2, 1022)));
    random_uploads(PHASE_ITEMS);
    write_chunk_bytes(10'($urandom_range(1, 64)));
    random_uploads(PHASE_ITEMS);

    // drain, then a short tail for stray results
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_count != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
    if (mismatch_count == 0 && pending_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
